### rtl/dual_gain_position_pid_macros.svh
// Assertion macros for the dual gain position PID block.
// Used by dual_gain_position_pid.sv; expects clk and rst_n in scope.
`ifndef DUAL_GAIN_POSITION_PID_MACROS_SVH
`define DUAL_GAIN_POSITION_PID_MACROS_SVH
`ifndef SYNTHESIS
`define DGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DGP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DGP_ASSERT(lbl, prop, msg)
`define DGP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/dgp_pkg.sv
// Shared types and constants for the dual gain position PID block.
// No dependencies; used by dual_gain_position_pid.
`timescale 1ns / 1ps
`default_nettype none
package dgp_pkg;

  localparam int SUM_WIDTH      = 32;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int GAIN_W         = 16;
  localparam int VAL_W          = 16;
  localparam int ERR_W          = VAL_W + 1;
  localparam int DRIVE_W        = 12;
  localparam int ADDR_W         = 5;
  localparam int DATA_W         = 32;
  localparam int MID_DRIVE      = 1500;
  localparam int LIMIT          = 1000;

  localparam logic [1:0] FUNC_OFF     = 2'd0;
  localparam logic [1:0] FUNC_DEPTH   = 2'd1;
  localparam logic [1:0] FUNC_HEADING = 2'd2;

  localparam logic [2:0] REG_DEPTH_KP   = 3'd0;
  localparam logic [2:0] REG_DEPTH_KI   = 3'd1;
  localparam logic [2:0] REG_DEPTH_KD   = 3'd2;
  localparam logic [2:0] REG_HEADING_KP = 3'd3;
  localparam logic [2:0] REG_HEADING_KI = 3'd4;
  localparam logic [2:0] REG_HEADING_KD = 3'd5;

  typedef struct packed {
    logic [1:0]        func;
    logic [VAL_W-1:0]  target;
    logic [VAL_W-1:0]  measured;
  } in_item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gain_set_t;

endpackage
`default_nettype wire

### rtl/dual_gain_position_pid.sv
// Dual gain positional PID: depth hold and heading hold gain sets.
// Each item is registered in stage 1, then its PID result is registered in the output stage.
// Throughput: one item per cycle unless out_stall holds a full pipe; in_stall only when both stages hold items
// and out_stall is high. The PID math is one pass between the two registers.
// Synchronous reset clears gains, error state and both valid flags.
// Depends on dgp_pkg and dual_gain_position_pid_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_gain_position_pid_macros.svh"
module dual_gain_position_pid (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire dgp_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output dgp_pkg::out_item_t               out_data,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [dgp_pkg::ADDR_W-1:0]        paddr,
  input  wire [dgp_pkg::DATA_W-1:0]        pwdata,
  output logic [dgp_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);

  localparam int SW    = dgp_pkg::SUM_WIDTH;
  localparam int EW    = dgp_pkg::ERR_W;
  localparam int GW    = dgp_pkg::GAIN_W;
  localparam int TOT_W = SW + GW + 2;
  localparam logic signed [TOT_W-1:0] RND_BIAS =
    TOT_W'((64'd1 << dgp_pkg::GAIN_FRAC_BITS) - 64'd1);
  localparam logic signed [TOT_W-1:0] POS_LIM = TOT_W'(dgp_pkg::LIMIT);
  localparam logic signed [TOT_W-1:0] NEG_LIM = -POS_LIM;
  localparam logic [dgp_pkg::DRIVE_W-1:0] MID = dgp_pkg::DRIVE_W'(dgp_pkg::MID_DRIVE);

  dgp_pkg::gain_set_t depth_gain_r, heading_gain_r;
  dgp_pkg::in_item_t  s1_item_r;
  dgp_pkg::out_item_t out_item_r, out_item_nxt;
  logic               s1_valid_r, out_valid_r;
  logic signed [EW-1:0] prev_err_r;
  logic signed [SW-1:0] error_sum_r;

  logic cfg_wr, s1_load, advance, active;
  dgp_pkg::gain_set_t gain;
  logic signed [EW-1:0]    err;
  logic signed [SW:0]      sum_wide;
  logic signed [SW-1:0]    sum_sat;
  logic signed [EW:0]      diff;
  logic signed [EW+GW-1:0] p_kp;
  logic signed [SW+GW-1:0] p_ki;
  logic signed [EW+GW:0]   p_kd;
  logic signed [TOT_W-1:0] total, total_b, scaled;
  logic signed [10:0]      val;
  logic                    hit;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_gain_r   <= '0;
      heading_gain_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        dgp_pkg::REG_DEPTH_KP:   depth_gain_r.kp   <= pwdata[GW-1:0];
        dgp_pkg::REG_DEPTH_KI:   depth_gain_r.ki   <= pwdata[GW-1:0];
        dgp_pkg::REG_DEPTH_KD:   depth_gain_r.kd   <= pwdata[GW-1:0];
        dgp_pkg::REG_HEADING_KP: heading_gain_r.kp <= pwdata[GW-1:0];
        dgp_pkg::REG_HEADING_KI: heading_gain_r.ki <= pwdata[GW-1:0];
        dgp_pkg::REG_HEADING_KD: heading_gain_r.kd <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      dgp_pkg::REG_DEPTH_KP:   prdata = {16'd0, depth_gain_r.kp};
      dgp_pkg::REG_DEPTH_KI:   prdata = {16'd0, depth_gain_r.ki};
      dgp_pkg::REG_DEPTH_KD:   prdata = {16'd0, depth_gain_r.kd};
      dgp_pkg::REG_HEADING_KP: prdata = {16'd0, heading_gain_r.kp};
      dgp_pkg::REG_HEADING_KI: prdata = {16'd0, heading_gain_r.ki};
      dgp_pkg::REG_HEADING_KD: prdata = {16'd0, heading_gain_r.kd};
      default:                 prdata = '0;
    endcase
  end

  // two-stage flow control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  // PID datapath
  assign active = (s1_item_r.func == dgp_pkg::FUNC_DEPTH) ||
                  (s1_item_r.func == dgp_pkg::FUNC_HEADING);
  assign gain   = (s1_item_r.func == dgp_pkg::FUNC_HEADING) ? heading_gain_r : depth_gain_r;

  assign err      = $signed({1'b0, s1_item_r.target}) - $signed({1'b0, s1_item_r.measured});
  assign sum_wide = $signed({error_sum_r[SW-1], error_sum_r}) +
                    $signed({{(SW+1-EW){err[EW-1]}}, err});
  assign sum_sat  = (sum_wide[SW] != sum_wide[SW-1]) ?
                    {sum_wide[SW], {(SW-1){~sum_wide[SW]}}} : sum_wide[SW-1:0];
  assign diff     = $signed({prev_err_r[EW-1], prev_err_r}) - $signed({err[EW-1], err});

  assign p_kp = $signed(gain.kp) * err;
  assign p_ki = $signed(gain.ki) * sum_sat;
  assign p_kd = $signed(gain.kd) * diff;

  assign total   = TOT_W'(p_kp) + TOT_W'(p_ki) + TOT_W'(p_kd);
  // truncate toward zero
  assign total_b = total[TOT_W-1] ? (total + RND_BIAS) : total;
  assign scaled  = total_b >>> dgp_pkg::GAIN_FRAC_BITS;

  always_comb begin
    hit = 1'b0;
    val = scaled[10:0];
    if (scaled > POS_LIM) begin
      val = POS_LIM[10:0];
      hit = 1'b1;
    end else if (scaled < NEG_LIM) begin
      val = NEG_LIM[10:0];
      hit = 1'b1;
    end
    if (active) begin
      out_item_nxt.drive   = MID + {val[10], val};
      out_item_nxt.clamped = hit;
    end else begin
      out_item_nxt.drive   = '0;
      out_item_nxt.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r  <= '0;
      error_sum_r <= '0;
    end else if (advance) begin
      if (active) begin
        prev_err_r  <= err;
        error_sum_r <= sum_sat;
      end else begin
        prev_err_r  <= '0;
        error_sum_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `DGP_ASSERT(a_stall_full, in_stall |-> (s1_valid_r && out_valid_r), "stall without full pipe")
  `DGP_ASSERT(a_off_clears, (advance && !active) |=> (error_sum_r == '0 && prev_err_r == '0), "off did not clear state")
  `DGP_ASSERT(a_drive_range, out_valid_r |-> (out_item_r.drive == '0 || (out_item_r.drive >= 12'd500 && out_item_r.drive <= 12'd2500)), "drive out of range")
  `DGP_ASSERT(a_clamp_edge, (out_valid_r && out_item_r.clamped) |-> (out_item_r.drive == 12'd500 || out_item_r.drive == 12'd2500), "clamp flag off the limit")

endmodule
`default_nettype wire
